// ----- design/dual_channel_meter_digits_assert.svh -----
// Assertion macros for the dual-channel meter digit block
`ifndef DUAL_CHANNEL_METER_DIGITS_ASSERT_SVH
`define DUAL_CHANNEL_METER_DIGITS_ASSERT_SVH

// Same-cycle implication, held off during reset
`define DCMD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dcmd: same-cycle check failed");

// Next-cycle implication, held off during reset
`define DCMD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dcmd: next-cycle check failed");

`endif

// ----- design/dcmd_pkg.sv -----
// Shared types, constants and widths of the dual-channel meter digit block
`default_nettype none

package dcmd_pkg;

    // Field widths
    localparam int SAMPLE_W  = 10;
    localparam int DIGIT_W   = 4;
    localparam int DIVISOR_W = 16;
    localparam int CFG_IDX_W = 1;

    // Defaults for the top-level parameters
    localparam int HISTORY_DEPTH_DEF = 6;
    localparam int UPDATE_PERIOD_DEF = 50;

    // Counters
    localparam int UPD_CNT_W  = 6;
    localparam int BLINK_W    = 8;
    localparam int BLINK_STEP = 4;

    // Calibration division: (avg << 8) / divisor, one quotient bit a cycle
    localparam int FRAC_W     = 8;
    localparam int QUO_W      = SAMPLE_W + FRAC_W;
    localparam int DIV_STEPS  = QUO_W;
    localparam int STEP_CNT_W = $clog2(DIV_STEPS);

    // Digit forming
    localparam int DISP_W     = 10;
    localparam int DISP_MAX   = 999;
    localparam int DISP_LIMIT = 1000;
    localparam int REM_W      = 7;
    localparam int HUND_MUL   = 41;
    localparam int HUND_SH    = 12;
    localparam int HUND_PW    = DISP_W + 6;
    localparam int TENS_MUL   = 205;
    localparam int TENS_SH    = 11;
    localparam int TENS_PW    = REM_W + 8;

    localparam logic [DIGIT_W-1:0] DIGIT_NINE  = 4'd9;
    localparam logic [DIGIT_W-1:0] DIGIT_BLANK = 4'd10;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_DIV = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AMP_DIV  = 1'd1;
    localparam logic [DIVISOR_W-1:0] VOLT_DIV_RST = 16'd1024;
    localparam logic [DIVISOR_W-1:0] AMP_DIV_RST  = 16'd256;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_AVG,
        ST_DIV,
        ST_HUND,
        ST_REM,
        ST_TENS,
        ST_UNITS,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic sum_en;
        logic div_load;
        logic div_step;
        logic hund_en;
        logic rem_en;
        logic tens_en;
        logic units_en;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic update_due;
    } stat_t;

endpackage

`default_nettype wire

// ----- design/dual_channel_meter_digits.sv -----
// Dual-channel meter digit former: top level
//
// Input channel (in_valid/in_ready) takes one voltage and one current sample
// per item; output channel (out_valid/out_ready) gives six display digits and
// the overload beep for every item, one result per item, in order.
// cfg_write/cfg_addr/cfg_data set the two Q8.8 calibration divisors; write
// them only while no item is in flight.
// An item passes the SUM, AVG and DONE states from acceptance to out_valid.
// Every UPDATE_PERIOD-th item refreshes the digits and also passes DIV: the
// two calibration divisions run side by side in a restoring divider that
// yields one quotient bit a cycle, followed by the HUND, REM, TENS and UNITS
// digit-forming states. One item is in flight at a time: the next item is
// taken only after the last result has been handed to the output register.
// in_ready is high while the controller is idle; a finished result sits in
// the output register, so the next item is accepted while it waits.
// When the receiver stalls, the following result waits in the controller
// until the output register is free, and no further item is taken.
// Reset clears the sample histories, the update and blink counters, the held
// digits (all zero) and sets the divisors to 4.00 and 1.00.
`default_nettype none

module dual_channel_meter_digits #(
    parameter int HISTORY_DEPTH = dcmd_pkg::HISTORY_DEPTH_DEF,
    parameter int UPDATE_PERIOD = dcmd_pkg::UPDATE_PERIOD_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [dcmd_pkg::SAMPLE_W-1:0]  voltage_sample,
    input  logic [dcmd_pkg::SAMPLE_W-1:0]  current_sample,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [dcmd_pkg::DIGIT_W-1:0]   volt_hundreds,
    output logic [dcmd_pkg::DIGIT_W-1:0]   volt_tens,
    output logic [dcmd_pkg::DIGIT_W-1:0]   volt_units,
    output logic [dcmd_pkg::DIGIT_W-1:0]   amp_hundreds,
    output logic [dcmd_pkg::DIGIT_W-1:0]   amp_tens,
    output logic [dcmd_pkg::DIGIT_W-1:0]   amp_units,
    output logic                           overload_beep,
    input  logic                           cfg_write,
    input  logic [dcmd_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [dcmd_pkg::DIVISOR_W-1:0] cfg_data
);

    dcmd_pkg::cmd_t  cmd;
    dcmd_pkg::stat_t stat;

    dcmd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .stat      (stat),
        .cmd       (cmd)
    );

    dcmd_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .UPDATE_PERIOD (UPDATE_PERIOD)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_write      (cfg_write),
        .cfg_addr       (cfg_addr),
        .cfg_data       (cfg_data),
        .voltage_sample (voltage_sample),
        .current_sample (current_sample),
        .volt_hundreds  (volt_hundreds),
        .volt_tens      (volt_tens),
        .volt_units     (volt_units),
        .amp_hundreds   (amp_hundreds),
        .amp_tens       (amp_tens),
        .amp_units      (amp_units),
        .overload_beep  (overload_beep)
    );

`include "dual_channel_meter_digits_assert.svh"

    // one item at a time: busy right after an item is taken
    `DCMD_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
    // the divider only runs for an item that refreshes the digits
    `DCMD_ASSERT_SAME(a_div_on_update, clk, rst_n, cmd.div_step, stat.update_due)
    // a result never overwrites one still waiting at the output
    `DCMD_ASSERT_SAME(a_no_overwrite, clk, rst_n, cmd.out_load, !out_valid || out_ready)

endmodule

`default_nettype wire

// ----- design/dcmd_ctrl.sv -----
// Controller state machine of the meter digit block
`default_nettype none

module dcmd_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            out_ready,
    output logic            out_valid,
    input  dcmd_pkg::stat_t stat,
    output dcmd_pkg::cmd_t  cmd
);

    dcmd_pkg::state_t                    state_reg, state_next;
    logic [dcmd_pkg::STEP_CNT_W-1:0]     step_reg, step_next;
    logic                                out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dcmd_pkg::ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        in_ready   = 1'b0;

        unique case (state_reg)
            dcmd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = dcmd_pkg::ST_SUM;
                end
            end
            dcmd_pkg::ST_SUM:
            begin
                cmd.sum_en = 1'b1;
                state_next = dcmd_pkg::ST_AVG;
            end
            dcmd_pkg::ST_AVG:
            begin
                cmd.div_load = 1'b1;
                step_next    = '0;
                state_next   = stat.update_due ? dcmd_pkg::ST_DIV : dcmd_pkg::ST_DONE;
            end
            dcmd_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == dcmd_pkg::STEP_CNT_W'(dcmd_pkg::DIV_STEPS - 1))
                begin
                    state_next = dcmd_pkg::ST_HUND;
                end
            end
            dcmd_pkg::ST_HUND:
            begin
                cmd.hund_en = 1'b1;
                state_next  = dcmd_pkg::ST_REM;
            end
            dcmd_pkg::ST_REM:
            begin
                cmd.rem_en = 1'b1;
                state_next = dcmd_pkg::ST_TENS;
            end
            dcmd_pkg::ST_TENS:
            begin
                cmd.tens_en = 1'b1;
                state_next  = dcmd_pkg::ST_UNITS;
            end
            dcmd_pkg::ST_UNITS:
            begin
                cmd.units_en = 1'b1;
                state_next   = dcmd_pkg::ST_DONE;
            end
            dcmd_pkg::ST_DONE:
            begin
                // hand over only when the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = dcmd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dcmd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- design/dcmd_datapath.sv -----
// Datapath of the meter digit block: history, averaging, division, digits
`default_nettype none

module dcmd_datapath #(
    parameter int HISTORY_DEPTH = dcmd_pkg::HISTORY_DEPTH_DEF,
    parameter int UPDATE_PERIOD = dcmd_pkg::UPDATE_PERIOD_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  dcmd_pkg::cmd_t                     cmd,
    output dcmd_pkg::stat_t                    stat,
    input  logic                               cfg_write,
    input  logic [dcmd_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [dcmd_pkg::DIVISOR_W-1:0]     cfg_data,
    input  logic [dcmd_pkg::SAMPLE_W-1:0]      voltage_sample,
    input  logic [dcmd_pkg::SAMPLE_W-1:0]      current_sample,
    output logic [dcmd_pkg::DIGIT_W-1:0]       volt_hundreds,
    output logic [dcmd_pkg::DIGIT_W-1:0]       volt_tens,
    output logic [dcmd_pkg::DIGIT_W-1:0]       volt_units,
    output logic [dcmd_pkg::DIGIT_W-1:0]       amp_hundreds,
    output logic [dcmd_pkg::DIGIT_W-1:0]       amp_tens,
    output logic [dcmd_pkg::DIGIT_W-1:0]       amp_units,
    output logic                               overload_beep
);

    localparam int SW      = dcmd_pkg::SAMPLE_W;
    localparam int DW      = dcmd_pkg::DIGIT_W;
    localparam int VW      = dcmd_pkg::DIVISOR_W;
    localparam int QW      = dcmd_pkg::QUO_W;
    localparam int PW      = dcmd_pkg::DISP_W;
    localparam int RW      = dcmd_pkg::REM_W;
    localparam int SUM_W   = $clog2(HISTORY_DEPTH * ((1 << SW) - 1) + 1);
    // sum / HISTORY_DEPTH as a multiply by a rounded-up reciprocal
    localparam int RSH     = SUM_W + 5;
    localparam int RECIP_W = RSH + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << RSH) + HISTORY_DEPTH - 1) / HISTORY_DEPTH);
    localparam int PROD_W  = SUM_W + RECIP_W;

    // Divider step: shift in the next dividend bit, subtract when it fits.
    // A zero divisor always fits, so the quotient saturates to all ones.
    function automatic logic [VW+QW-1:0] div_iter(
        input logic [VW-1:0] rem,
        input logic [QW-1:0] quo,
        input logic [VW-1:0] dvs
    );
        logic [VW:0] shifted;
        logic [VW:0] diff;
        shifted = {rem, quo[QW-1]};
        diff    = shifted - {1'b0, dvs};
        if (shifted >= {1'b0, dvs})
        begin
            div_iter = {diff[VW-1:0], quo[QW-2:0], 1'b1};
        end
        else
        begin
            div_iter = {shifted[VW-1:0], quo[QW-2:0], 1'b0};
        end
    endfunction

    // Configuration
    logic [VW-1:0] v_divisor_reg, a_divisor_reg;

    // History shift lines and counters
    logic [SW-1:0]                     v_hist_reg [HISTORY_DEPTH];
    logic [SW-1:0]                     a_hist_reg [HISTORY_DEPTH];
    logic [dcmd_pkg::UPD_CNT_W-1:0]    upd_cnt_reg, upd_cnt_next;
    logic [dcmd_pkg::BLINK_W-1:0]      blink_reg;
    logic                              due_reg;
    logic                              blink_on_reg;

    // Averaging
    logic [SUM_W-1:0]  v_sum, a_sum, v_sum_reg, a_sum_reg;
    logic [PROD_W-1:0] v_prod, a_prod;

    // Division lanes
    logic [VW-1:0]    v_dr_reg, a_dr_reg;
    logic [QW-1:0]    v_q_reg, a_q_reg;
    logic [VW+QW-1:0] v_iter, a_iter;

    // Digit forming
    logic [PW-1:0]             v_val, a_val, v_val_reg, a_val_reg;
    logic [dcmd_pkg::HUND_PW-1:0] v_hprod, a_hprod;
    logic [DW-1:0]             v_h_reg, a_h_reg, v_t_reg, a_t_reg;
    logic                      a_ovl_reg;
    logic [RW-1:0]             v_r_reg, a_r_reg;
    logic [dcmd_pkg::TENS_PW-1:0] v_tprod, a_tprod;
    logic [RW-1:0]             v_u, a_u;

    // Held and output digits
    logic [DW-1:0] held_reg [6];
    logic          held_beep_reg;
    logic [DW-1:0] out_reg [6];
    logic          out_beep_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_divisor_reg <= dcmd_pkg::VOLT_DIV_RST;
            a_divisor_reg <= dcmd_pkg::AMP_DIV_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_addr)
                dcmd_pkg::CFG_VOLT_DIV: v_divisor_reg <= cfg_data;
                dcmd_pkg::CFG_AMP_DIV:  a_divisor_reg <= cfg_data;
                default:                v_divisor_reg <= v_divisor_reg;
            endcase
        end
    end

    always_comb
    begin
        if (upd_cnt_reg + 1'b1 >= dcmd_pkg::UPD_CNT_W'(UPDATE_PERIOD))
        begin
            upd_cnt_next = '0;
        end
        else
        begin
            upd_cnt_next = upd_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < HISTORY_DEPTH; k++)
            begin
                v_hist_reg[k] <= '0;
                a_hist_reg[k] <= '0;
            end
            upd_cnt_reg  <= '0;
            blink_reg    <= '0;
            due_reg      <= 1'b0;
            blink_on_reg <= 1'b0;
        end
        else if (cmd.accept)
        begin
            for (int k = 0; k < HISTORY_DEPTH - 1; k++)
            begin
                v_hist_reg[k] <= v_hist_reg[k + 1];
                a_hist_reg[k] <= a_hist_reg[k + 1];
            end
            v_hist_reg[HISTORY_DEPTH - 1] <= voltage_sample;
            a_hist_reg[HISTORY_DEPTH - 1] <= current_sample;
            // sample the counters before they advance
            due_reg      <= (upd_cnt_reg == '0);
            blink_on_reg <= blink_reg[dcmd_pkg::BLINK_W - 1];
            upd_cnt_reg  <= upd_cnt_next;
            blink_reg    <= blink_reg + dcmd_pkg::BLINK_W'(dcmd_pkg::BLINK_STEP);
        end
    end

    assign stat.update_due = due_reg;

    always_comb
    begin
        v_sum = '0;
        a_sum = '0;
        for (int k = 0; k < HISTORY_DEPTH; k++)
        begin
            v_sum = v_sum + SUM_W'(v_hist_reg[k]);
            a_sum = a_sum + SUM_W'(a_hist_reg[k]);
        end
    end

    assign v_prod = PROD_W'(v_sum_reg) * PROD_W'(RECIP);
    assign a_prod = PROD_W'(a_sum_reg) * PROD_W'(RECIP);

    assign v_iter = div_iter(v_dr_reg, v_q_reg, v_divisor_reg);
    assign a_iter = div_iter(a_dr_reg, a_q_reg, a_divisor_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.sum_en)
        begin
            v_sum_reg <= v_sum;
            a_sum_reg <= a_sum;
        end
        if (cmd.div_load)
        begin
            v_q_reg  <= {v_prod[RSH +: SW], {dcmd_pkg::FRAC_W{1'b0}}};
            a_q_reg  <= {a_prod[RSH +: SW], {dcmd_pkg::FRAC_W{1'b0}}};
            v_dr_reg <= '0;
            a_dr_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            {v_dr_reg, v_q_reg} <= v_iter;
            {a_dr_reg, a_q_reg} <= a_iter;
        end
    end

    // Hundreds by multiply with 41/4096, exact below 1000
    always_comb
    begin
        if (v_q_reg > QW'(dcmd_pkg::DISP_MAX))
        begin
            v_val = PW'(dcmd_pkg::DISP_MAX);
        end
        else
        begin
            v_val = v_q_reg[PW-1:0];
        end
        a_val   = a_q_reg[PW-1:0];
        v_hprod = dcmd_pkg::HUND_PW'(v_val) * dcmd_pkg::HUND_PW'(dcmd_pkg::HUND_MUL);
        a_hprod = dcmd_pkg::HUND_PW'(a_val) * dcmd_pkg::HUND_PW'(dcmd_pkg::HUND_MUL);
    end

    // Tens by multiply with 205/2048, exact below 100
    assign v_tprod = dcmd_pkg::TENS_PW'(v_r_reg) * dcmd_pkg::TENS_PW'(dcmd_pkg::TENS_MUL);
    assign a_tprod = dcmd_pkg::TENS_PW'(a_r_reg) * dcmd_pkg::TENS_PW'(dcmd_pkg::TENS_MUL);
    assign v_u     = v_r_reg - RW'(v_t_reg) * RW'(10);
    assign a_u     = a_r_reg - RW'(a_t_reg) * RW'(10);

    always_ff @(posedge clk)
    begin
        if (cmd.hund_en)
        begin
            v_val_reg <= v_val;
            a_val_reg <= a_val;
            v_h_reg   <= v_hprod[dcmd_pkg::HUND_SH +: DW];
            a_h_reg   <= a_hprod[dcmd_pkg::HUND_SH +: DW];
            a_ovl_reg <= (a_q_reg >= QW'(dcmd_pkg::DISP_LIMIT));
        end
        if (cmd.rem_en)
        begin
            v_r_reg <= RW'(v_val_reg - PW'(v_h_reg) * PW'(100));
            a_r_reg <= RW'(a_val_reg - PW'(a_h_reg) * PW'(100));
        end
        if (cmd.tens_en)
        begin
            v_t_reg <= v_tprod[dcmd_pkg::TENS_SH +: DW];
            a_t_reg <= a_tprod[dcmd_pkg::TENS_SH +: DW];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 6; k++)
            begin
                held_reg[k] <= '0;
            end
            held_beep_reg <= 1'b0;
        end
        else if (cmd.units_en)
        begin
            // blank a leading voltage zero
            held_reg[0] <= (v_h_reg == '0) ? dcmd_pkg::DIGIT_BLANK : v_h_reg;
            held_reg[1] <= v_t_reg;
            held_reg[2] <= v_u[DW-1:0];
            if (a_ovl_reg)
            begin
                for (int k = 3; k < 6; k++)
                begin
                    held_reg[k] <= blink_on_reg ? dcmd_pkg::DIGIT_NINE
                                                : dcmd_pkg::DIGIT_BLANK;
                end
                held_beep_reg <= blink_on_reg;
            end
            else
            begin
                held_reg[3]   <= a_h_reg;
                held_reg[4]   <= a_t_reg;
                held_reg[5]   <= a_u[DW-1:0];
                held_beep_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            for (int k = 0; k < 6; k++)
            begin
                out_reg[k] <= held_reg[k];
            end
            out_beep_reg <= held_beep_reg;
        end
    end

    assign volt_hundreds = out_reg[0];
    assign volt_tens     = out_reg[1];
    assign volt_units    = out_reg[2];
    assign amp_hundreds  = out_reg[3];
    assign amp_tens      = out_reg[4];
    assign amp_units     = out_reg[5];
    assign overload_beep = out_beep_reg;

endmodule

`default_nettype wire

// ----- tb/sv/dual_channel_meter_digits_tb.sv -----
// Testbench for the dual-channel meter digit former: directed and random items, scoreboard check
`timescale 1ns / 100ps

module dual_channel_meter_digits_tb;
    import dcmd_pkg::*;

    localparam int DEPTH         = HISTORY_DEPTH_DEF;
    localparam int PERIOD        = UPDATE_PERIOD_DEF;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 300;
    localparam int RANDOM_ITEMS  = 200;
    localparam int NOISE_LEVEL   = -1;

    typedef struct packed {
        logic [DIGIT_W-1:0] volt_hundreds;
        logic [DIGIT_W-1:0] volt_tens;
        logic [DIGIT_W-1:0] volt_units;
        logic [DIGIT_W-1:0] amp_hundreds;
        logic [DIGIT_W-1:0] amp_tens;
        logic [DIGIT_W-1:0] amp_units;
        logic               overload_beep;
    } meter_readout_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [SAMPLE_W-1:0]  voltage_sample;
    logic [SAMPLE_W-1:0]  current_sample;
    logic                 out_valid;
    logic                 out_ready;
    logic [DIGIT_W-1:0]   volt_hundreds;
    logic [DIGIT_W-1:0]   volt_tens;
    logic [DIGIT_W-1:0]   volt_units;
    logic [DIGIT_W-1:0]   amp_hundreds;
    logic [DIGIT_W-1:0]   amp_tens;
    logic [DIGIT_W-1:0]   amp_units;
    logic                 overload_beep;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [DIVISOR_W-1:0] cfg_data;

    // Model state of the block
    logic [SAMPLE_W-1:0]  volt_hist [DEPTH];
    logic [SAMPLE_W-1:0]  amp_hist [DEPTH];
    int                   model_update_cnt;
    logic [BLINK_W-1:0]   model_blink;
    meter_readout_t       model_held;
    logic [DIVISOR_W-1:0] model_volt_div;
    logic [DIVISOR_W-1:0] model_amp_div;

    meter_readout_t expected_readouts[$];
    int             fail_count;
    int             cycle_count;
    int             sender_idle_pct;
    int             receiver_stall_pct;
    int             hold_off_request;
    int             stall_left;

    dual_channel_meter_digits i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .voltage_sample (voltage_sample),
        .current_sample (current_sample),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .volt_hundreds  (volt_hundreds),
        .volt_tens      (volt_tens),
        .volt_units     (volt_units),
        .amp_hundreds   (amp_hundreds),
        .amp_tens       (amp_tens),
        .amp_units      (amp_units),
        .overload_beep  (overload_beep),
        .cfg_write      (cfg_write),
        .cfg_addr       (cfg_addr),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_off_request != 0)
        begin
            stall_left = hold_off_request;
            hold_off_request = 0;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99, 0) >= receiver_stall_pct);
        end
    end

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : readout_check
        meter_readout_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_readouts.size() == 0)
            begin
                $error("readout with no item outstanding");
                fail_count++;
            end
            else
            begin
                want = expected_readouts.pop_front();
                check_field("volt_hundreds", want.volt_hundreds, volt_hundreds);
                check_field("volt_tens", want.volt_tens, volt_tens);
                check_field("volt_units", want.volt_units, volt_units);
                check_field("amp_hundreds", want.amp_hundreds, amp_hundreds);
                check_field("amp_tens", want.amp_tens, amp_tens);
                check_field("amp_units", want.amp_units, amp_units);
                check_field("overload_beep", want.overload_beep, overload_beep);
            end
        end
    end

    function automatic void reset_model();
        for (int k = 0; k < DEPTH; k++)
        begin
            volt_hist[k] = '0;
            amp_hist[k] = '0;
        end
        model_update_cnt = 0;
        model_blink = '0;
        model_held = '0;
        model_volt_div = VOLT_DIV_RST;
        model_amp_div = AMP_DIV_RST;
    endfunction

    // Advance the model by one item and return the digits it shows
    function automatic meter_readout_t predict_readout(logic [SAMPLE_W-1:0] v_sample,
                                                       logic [SAMPLE_W-1:0] a_sample);
        int unsigned v_sum;
        int unsigned a_sum;
        int unsigned v_val;
        int unsigned a_val;
        v_sum = 0;
        a_sum = 0;
        for (int k = 0; k < DEPTH - 1; k++)
        begin
            volt_hist[k] = volt_hist[k + 1];
            amp_hist[k] = amp_hist[k + 1];
        end
        volt_hist[DEPTH - 1] = v_sample;
        amp_hist[DEPTH - 1] = a_sample;
        for (int k = 0; k < DEPTH; k++)
        begin
            v_sum += volt_hist[k];
            a_sum += amp_hist[k];
        end

        if (model_update_cnt == 0)
        begin
            // Zero divisor saturates the quotient
            v_val = (model_volt_div == 0) ? 32'hFFFF_FFFF
                  : ((v_sum / DEPTH) * 256) / model_volt_div;
            a_val = (model_amp_div == 0) ? 32'hFFFF_FFFF
                  : ((a_sum / DEPTH) * 256) / model_amp_div;

            if (v_val > DISP_MAX)
                v_val = DISP_MAX;
            model_held.volt_hundreds = (v_val < 100) ? DIGIT_BLANK : DIGIT_W'(v_val / 100);
            model_held.volt_tens = DIGIT_W'((v_val / 10) % 10);
            model_held.volt_units = DIGIT_W'(v_val % 10);

            if (a_val >= DISP_LIMIT)
            begin
                if (model_blink[7])
                begin
                    model_held.amp_hundreds = DIGIT_NINE;
                    model_held.amp_tens = DIGIT_NINE;
                    model_held.amp_units = DIGIT_NINE;
                    model_held.overload_beep = 1'b1;
                end
                else
                begin
                    model_held.amp_hundreds = DIGIT_BLANK;
                    model_held.amp_tens = DIGIT_BLANK;
                    model_held.amp_units = DIGIT_BLANK;
                    model_held.overload_beep = 1'b0;
                end
            end
            else
            begin
                model_held.amp_hundreds = DIGIT_W'(a_val / 100);
                model_held.amp_tens = DIGIT_W'((a_val / 10) % 10);
                model_held.amp_units = DIGIT_W'(a_val % 10);
                model_held.overload_beep = 1'b0;
            end
        end

        model_update_cnt++;
        if (model_update_cnt >= PERIOD)
            model_update_cnt = 0;
        model_blink = model_blink + BLINK_W'(BLINK_STEP);
        return model_held;
    endfunction

    task automatic send_item(logic [SAMPLE_W-1:0] v_sample, logic [SAMPLE_W-1:0] a_sample);
        while ($urandom_range(99, 0) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        voltage_sample <= v_sample;
        current_sample <= a_sample;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_readouts.push_back(predict_readout(v_sample, a_sample));
    endtask

    // Hold the sender until every outstanding item has come back
    task automatic wait_for_readouts();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_readouts.size() != 0);
    endtask

    task automatic set_divisors(logic [DIVISOR_W-1:0] v_div, logic [DIVISOR_W-1:0] a_div);
        cfg_write <= 1'b1;
        cfg_addr <= CFG_VOLT_DIV;
        cfg_data <= v_div;
        @(posedge clk);
        cfg_addr <= CFG_AMP_DIV;
        cfg_data <= a_div;
        @(posedge clk);
        cfg_write <= 1'b0;
        model_volt_div = v_div;
        model_amp_div = a_div;
    endtask

    // Send steady samples so the history is full at the digit update they end on
    task automatic hold_levels(logic [SAMPLE_W-1:0] v_level, logic [SAMPLE_W-1:0] a_level);
        int lead;
        lead = (model_update_cnt == 0) ? 0 : PERIOD - model_update_cnt;
        if (lead < DEPTH - 1)
            lead += PERIOD;
        repeat (lead + 1)
            send_item(v_level, a_level);
    endtask

    function automatic int pick_level();
        case ($urandom_range(5, 0))
            0: return $urandom_range(12, 0);
            1: return $urandom_range(400, 13);
            2: return $urandom_range(989, 401);
            3: return $urandom_range(1023, 990);
            default: return NOISE_LEVEL;
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] draw_sample(int level);
        int raw;
        if (level == NOISE_LEVEL)
            return SAMPLE_W'($urandom_range(1023, 0));
        raw = level + $urandom_range(3, 0);
        return SAMPLE_W'((raw > 1023) ? 1023 : raw);
    endfunction

    function automatic logic [DIVISOR_W-1:0] pick_divisor();
        case ($urandom_range(4, 0))
            0: return 16'd256;
            1: return 16'd1024;
            2: return DIVISOR_W'($urandom_range(1100, 128));
            3: return DIVISOR_W'($urandom_range(65535, 1));
            default: return DIVISOR_W'($urandom_range(3, 0));
        endcase
    endfunction

    task automatic test_field_extremes();
        logic [SAMPLE_W-1:0] pattern [8] = '{10'h3FF, 10'h000, 10'h155, 10'h2AA,
                                             10'h001, 10'h200, 10'h3FE, 10'h0FF};
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        for (int i = 0; i < 24; i++)
            send_item(pattern[i % 8], pattern[7 - i % 8]);
        wait_for_readouts();
    endtask

    task automatic test_leading_zero();
        sender_idle_pct = 67;
        receiver_stall_pct = 0;
        // Quotient below ten, then below a hundred, then full three digits
        hold_levels(10'd36, 10'd5);
        hold_levels(10'd300, 10'd470);
        hold_levels(10'd800, 10'd999);
        wait_for_readouts();
    endtask

    task automatic test_saturation_and_overload();
        sender_idle_pct = 0;
        receiver_stall_pct = 67;
        set_divisors(16'd256, 16'd256);
        // Four updates in a row cover both blink phases
        hold_levels(10'd1023, 10'd1023);
        hold_levels(10'd1000, 10'd1000);
        hold_levels(10'd999, 10'd1023);
        hold_levels(10'd1023, 10'd1000);
        wait_for_readouts();
    endtask

    task automatic test_divisor_extremes();
        sender_idle_pct = 28;
        receiver_stall_pct = 28;
        set_divisors(16'd0, 16'd0);
        hold_levels(10'd500, 10'd0);
        wait_for_readouts();
        set_divisors(16'd1, 16'd1);
        hold_levels(10'd0, 10'd1);
        hold_levels(10'd1, 10'd0);
        wait_for_readouts();
        set_divisors(16'hFFFF, 16'hFFFF);
        hold_levels(10'd1023, 10'd1023);
        wait_for_readouts();
    endtask

    task automatic test_backpressure();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        set_divisors(16'd1024, 16'd256);
        hold_off_request = LONG_HOLD;
        repeat (40)
            send_item(SAMPLE_W'($urandom_range(1023, 0)), SAMPLE_W'($urandom_range(1023, 0)));
        wait_for_readouts();
    endtask

    task automatic test_random_traffic();
        int send_pct [4] = '{0, 67, 0, 28};
        int stall_pct [4] = '{0, 0, 67, 28};
        int v_level;
        int a_level;
        for (int phase = 0; phase < 4; phase++)
        begin
            sender_idle_pct = send_pct[phase];
            receiver_stall_pct = stall_pct[phase];
            set_divisors(pick_divisor(), pick_divisor());
            v_level = pick_level();
            a_level = pick_level();
            repeat (RANDOM_ITEMS)
            begin
                // New levels right after each digit update
                if (model_update_cnt == 1)
                begin
                    v_level = pick_level();
                    a_level = pick_level();
                end
                send_item(draw_sample(v_level), draw_sample(a_level));
            end
            wait_for_readouts();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        voltage_sample = '0;
        current_sample = '0;
        out_ready = 1'b0;
        cfg_write = 1'b0;
        cfg_addr = CFG_VOLT_DIV;
        cfg_data = '0;
        fail_count = 0;
        cycle_count = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_off_request = 0;
        stall_left = 0;
        reset_model();

        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;

        test_field_extremes();
        test_leading_zero();
        test_saturation_and_overload();
        test_divisor_extremes();
        test_backpressure();
        test_random_traffic();

        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (fail_count == 0 && expected_readouts.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
